// ----- rtl/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// shared types, widths and codes of the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

  // default screen geometry
  localparam int DEF_COLUMNS   = 80;
  localparam int DEF_ROWS      = 25;
  localparam int DEF_TAB_WIDTH = 8;

  // port widths
  localparam int CMD_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int ATTR_W     = 8;
  localparam int CELL_W     = CHAR_W + ATTR_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_ATTR = 2'd1;

  // character codes
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // reset attributes
  localparam logic [ATTR_W-1:0] ATTR_RESET_TEXT   = 8'h07;
  localparam logic [ATTR_W-1:0] ATTR_RESET_SCROLL = 8'h0F;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_MOVE  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_FILL,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/tcw_ram.sv -----
// ----------------------------------------------------------------------------
// tcw_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_writer
// character-cell text screen with cursor, put / clear / move / read commands
// ----------------------------------------------------------------------------
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  command | cmd_valid, cmd_stall, cmd, char_code,      | in
//          | col, row                                   |
//  result  | rsp_valid, rsp_stall, cursor_col_out,      | out
//          | cursor_row_out, cell_char, cell_attr       |
//  config  | cfg_we, cfg_index, cfg_data                | in
//
//  put and move go straight to the done state; read first passes the read
//  state for the registered ram read; a scroll adds a fill pass: the screen
//  is a ring of rows, so scrolling bumps the top row pointer and blanks one
//  row through the single ram write port; clear fills every cell, one cell
//  write per cycle; after reset a clearing pass over all COLUMNS*ROWS cells
//  runs before the first command beat is taken; config writes are taken during it
//  a stalled result sits in the output register while the next command
//  is already being worked on
//
module text_console_writer #(
  parameter int COLUMNS   = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS      = tcw_pkg::DEF_ROWS,
  parameter int TAB_WIDTH = tcw_pkg::DEF_TAB_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  // command channel
  input  logic                           cmd_valid,
  output logic                           cmd_stall,
  input  logic [tcw_pkg::CMD_W-1:0]      cmd,
  input  logic [tcw_pkg::CHAR_W-1:0]     char_code,
  input  logic [tcw_pkg::COL_W-1:0]      col,
  input  logic [tcw_pkg::ROW_W-1:0]      row,
  // result channel
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic [tcw_pkg::COL_W-1:0]      cursor_col_out,
  output logic [tcw_pkg::ROW_W-1:0]      cursor_row_out,
  output logic [tcw_pkg::CHAR_W-1:0]     cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]     cell_attr,
  // configuration
  input  logic                           cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data
);

  import tcw_pkg::*;

  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int CUR_C_W = $clog2(COLUMNS);
  localparam int CUR_R_W = $clog2(ROWS);
  localparam int PHYS_W  = CUR_R_W + 1;
  // room for the wider of the input column and cursor plus a tab step
  localparam int CALC_W  = (COL_W > $clog2(COLUMNS + TAB_WIDTH)) ?
                           COL_W : $clog2(COLUMNS + TAB_WIDTH);
  // room for the input row and for ROWS itself
  localparam int RCALC_W = (ROW_W > $clog2(ROWS + 1)) ? ROW_W : $clog2(ROWS + 1);

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  state_t               state, state_next;
  logic [CUR_C_W-1:0]   cursor_col;
  logic [CUR_R_W-1:0]   cursor_row;
  logic [CUR_R_W-1:0]   top_row;       // physical row shown as row 0
  logic [ATTR_W-1:0]    text_attr;
  logic [ATTR_W-1:0]    scroll_attr;
  logic [ADDR_W-1:0]    fill_addr;
  logic [ADDR_W-1:0]    fill_last;
  logic [CELL_W-1:0]    fill_data;
  logic                 pending;       // a result is owed once the sweep ends
  logic [CHAR_W-1:0]    rd_char;
  logic [ATTR_W-1:0]    rd_attr;

  // ram ports
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [CELL_W-1:0]    ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [CELL_W-1:0]    ram_rdata;

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------
  // screen row to ram row through the ring offset
  function automatic logic [CUR_R_W-1:0] phys_row(input logic [CUR_R_W-1:0] lrow,
                                                  input logic [CUR_R_W-1:0] top);
    logic [PHYS_W-1:0] sum;
    sum = PHYS_W'(lrow) + PHYS_W'(top);
    if (sum >= PHYS_W'(ROWS)) begin
      sum = sum - PHYS_W'(ROWS);
    end
    return CUR_R_W'(sum);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [CUR_R_W-1:0] prow,
                                                  input logic [CUR_C_W-1:0] c);
    return ADDR_W'(ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(c));
  endfunction

  // next tab stop for every cursor column
  logic [CALC_W-1:0] tab_stop [2**CUR_C_W];

  for (genvar i = 0; i < 2**CUR_C_W; i++) begin : g_tab
    assign tab_stop[i] = CALC_W'(i + TAB_WIDTH - (i % TAB_WIDTH));
  end

  // --------------------------------------------------------------------------
  // command decode, cursor update
  // --------------------------------------------------------------------------
  cmd_t                op;
  logic                accept;
  logic                printable;
  logic [CALC_W-1:0]   put_col;
  logic [RCALC_W-1:0]  put_row;
  logic [CALC_W-1:0]   mv_col;
  logic [CALC_W-1:0]   new_col;
  logic [RCALC_W-1:0]  new_row;
  logic                scroll;
  logic [CUR_C_W-1:0]  cursor_col_next;
  logic [CUR_R_W-1:0]  cursor_row_next;
  logic [CUR_R_W-1:0]  top_row_next;
  logic [ADDR_W-1:0]   scroll_start;
  logic                rd_ok;
  logic                load_rsp;

  assign op        = cmd_t'(cmd);
  assign cmd_stall = (state != ST_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  // bytes with the top bit set are not printable and are dropped
  assign printable = (char_code >= CH_SPACE) && !char_code[CHAR_W-1];

  always_comb begin
    put_col = CALC_W'(cursor_col);
    put_row = RCALC_W'(cursor_row);
    case (char_code)
      CH_BS: begin
        if (cursor_col != '0) begin
          put_col = CALC_W'(cursor_col) - CALC_W'(1);
        end
      end
      CH_TAB: begin
        put_col = tab_stop[cursor_col];
      end
      CH_CR: begin
        put_col = '0;
      end
      CH_LF: begin
        put_col = '0;
        put_row = RCALC_W'(cursor_row) + RCALC_W'(1);
      end
      default: begin
        if (printable) begin
          put_col = CALC_W'(cursor_col) + CALC_W'(1);
        end
      end
    endcase
    // wrap at the right edge
    if (put_col >= CALC_W'(COLUMNS)) begin
      put_col = '0;
      put_row = put_row + RCALC_W'(1);
    end
  end

  // move saturates the column at the right edge
  assign mv_col = (CALC_W'(col) >= CALC_W'(COLUMNS)) ? CALC_W'(COLUMNS - 1) : CALC_W'(col);

  always_comb begin
    case (op)
      CMD_PUT: begin
        new_col = put_col;
        new_row = put_row;
      end
      CMD_MOVE: begin
        new_col = mv_col;
        new_row = RCALC_W'(row);
      end
      CMD_CLEAR: begin
        new_col = '0;
        new_row = '0;
      end
      default: begin
        new_col = CALC_W'(cursor_col);
        new_row = RCALC_W'(cursor_row);
      end
    endcase
  end

  // running off the bottom scrolls one row
  assign scroll          = ((op == CMD_PUT) || (op == CMD_MOVE)) &&
                           (new_row >= RCALC_W'(ROWS));
  assign cursor_col_next = CUR_C_W'(new_col);
  assign cursor_row_next = scroll ? CUR_R_W'(ROWS - 1) : CUR_R_W'(new_row);
  assign top_row_next    = (top_row == CUR_R_W'(ROWS - 1)) ? '0 : top_row + CUR_R_W'(1);
  // the old top row becomes the blank bottom row
  assign scroll_start    = cell_addr(top_row, '0);

  assign rd_ok = (CALC_W'(col) < CALC_W'(COLUMNS)) && (RCALC_W'(row) < RCALC_W'(ROWS));

  // --------------------------------------------------------------------------
  // screen memory
  // --------------------------------------------------------------------------
  always_comb begin
    if (state == ST_FILL) begin
      ram_we    = 1'b1;
      ram_waddr = fill_addr;
      ram_wdata = fill_data;
    end else begin
      ram_we    = accept && (op == CMD_PUT) && printable;
      ram_waddr = cell_addr(phys_row(cursor_row, top_row), cursor_col);
      ram_wdata = {text_attr, char_code};
    end
  end

  assign ram_raddr = cell_addr(phys_row(CUR_R_W'(row), top_row), CUR_C_W'(col));

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // control
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;   // clearing pass
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load_rsp   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            CMD_CLEAR: state_next = ST_FILL;
            CMD_READ:  state_next = rd_ok ? ST_READ : ST_DONE;
            default:   state_next = scroll ? ST_FILL : ST_DONE;
          endcase
        end
      end
      ST_READ: begin
        state_next = ST_DONE;
      end
      ST_FILL: begin
        if (fill_addr == fill_last) begin
          state_next = pending ? ST_DONE : ST_IDLE;
        end
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!rsp_valid || !rsp_stall) begin
          load_rsp   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // datapath
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col  <= '0;
      cursor_row  <= '0;
      top_row     <= '0;
      text_attr   <= ATTR_RESET_TEXT;
      scroll_attr <= ATTR_RESET_SCROLL;
      fill_addr   <= '0;
      fill_last   <= ADDR_W'(CELLS - 1);
      fill_data   <= {ATTR_RESET_TEXT, CH_SPACE};
      pending     <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TEXT_ATTR:   text_attr   <= ATTR_W'(cfg_data);
          REG_SCROLL_ATTR: scroll_attr <= ATTR_W'(cfg_data);
          default: ;
        endcase
      end

      if (accept) begin
        cursor_col <= cursor_col_next;
        cursor_row <= cursor_row_next;
        pending    <= 1'b1;
        rd_char    <= '0;
        rd_attr    <= '0;
        if (op == CMD_CLEAR) begin
          top_row   <= '0;
          fill_addr <= '0;
          fill_last <= ADDR_W'(CELLS - 1);
          fill_data <= {text_attr, CH_SPACE};
        end else if (scroll) begin
          top_row   <= top_row_next;
          fill_addr <= scroll_start;
          fill_last <= scroll_start + ADDR_W'(COLUMNS - 1);
          fill_data <= {scroll_attr, CH_SPACE};
        end
      end

      if (state == ST_FILL) begin
        fill_addr <= fill_addr + ADDR_W'(1);
      end

      if (state == ST_READ) begin
        rd_char <= ram_rdata[CHAR_W-1:0];
        rd_attr <= ram_rdata[CELL_W-1:CHAR_W];
      end

      // output register
      if (load_rsp) begin
        rsp_valid <= 1'b1;
        pending   <= 1'b0;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    if (load_rsp) begin
      cursor_col_out <= COL_W'(cursor_col);
      cursor_row_out <= ROW_W'(cursor_row);
      cell_char      <= rd_char;
      cell_attr      <= rd_attr;
    end
  end

endmodule

// ----- rtl/tcw_checker.sv -----
// ----------------------------------------------------------------------------
// tcw_checker
// port-level checks of the text console writer, bound to the top level
// ----------------------------------------------------------------------------
module tcw_checker #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       cmd_valid,
  input logic                       cmd_stall,
  input logic                       rsp_valid,
  input logic                       rsp_stall,
  input logic [tcw_pkg::COL_W-1:0]  cursor_col_out,
  input logic [tcw_pkg::ROW_W-1:0]  cursor_row_out,
  input logic [tcw_pkg::CHAR_W-1:0] cell_char,
  input logic [tcw_pkg::ATTR_W-1:0] cell_attr
);

  import tcw_pkg::*;

  // clearing pass holds off commands right after reset
  a_init_stall: assert property (@(posedge clk) rst |=> cmd_stall)
    else $error("command taken during clearing pass");

  // one command in flight
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> cmd_stall)
    else $error("second command taken back to back");

  // cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((32'(cursor_col_out) < COLUMNS) && (32'(cursor_row_out) < ROWS)))
    else $error("cursor off screen");

  // cells only ever hold spaces or printable bytes; a result that read no cell carries zero
  a_cell_char: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((cell_char == '0) ||
                   ((cell_char >= CH_SPACE) && !cell_char[CHAR_W-1])))
    else $error("unprintable character read back");

  // stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(cursor_col_out) &&
      $stable(cursor_row_out) && $stable(cell_char) && $stable(cell_attr)))
    else $error("stalled result beat changed");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd_valid),
  .cmd_stall      (cmd_stall),
  .rsp_valid      (rsp_valid),
  .rsp_stall      (rsp_stall),
  .cursor_col_out (cursor_col_out),
  .cursor_row_out (cursor_row_out),
  .cell_char      (cell_char),
  .cell_attr      (cell_attr)
);
